[rtl/mksd_pkg.sv]
// ============================================================================
// Morse key stream decoder package
// Shared types, character codes and the Morse code table.
// ============================================================================
`default_nettype none

package mksd_pkg;

   localparam int unsigned CHAR_W = 7;
   localparam int unsigned SLOTS = 4;
   localparam int unsigned COUNT_W = 3;

   localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3F;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

   typedef logic [CHAR_W-1:0] char_type;

   // Result characters of one input item, handed to the result buffer.
   typedef struct packed {
      logic                 load;
      logic [COUNT_W-1:0]   count;
      char_type [SLOTS-1:0] chars;
   } burst_type;

   // The code holds the elements with the first one in the most significant
   // used bit; a one is a dash.
   function automatic char_type morse_lookup(logic [2:0] len, logic [6:0] code);
      char_type ch;
      ch = CHAR_UNKNOWN;
      unique case ({len, code})
         {3'd2, 7'd1}:  ch = 7'h41;
         {3'd4, 7'd8}:  ch = 7'h42;
         {3'd4, 7'd10}: ch = 7'h43;
         {3'd3, 7'd4}:  ch = 7'h44;
         {3'd1, 7'd0}:  ch = 7'h45;
         {3'd4, 7'd2}:  ch = 7'h46;
         {3'd3, 7'd6}:  ch = 7'h47;
         {3'd4, 7'd0}:  ch = 7'h48;
         {3'd2, 7'd0}:  ch = 7'h49;
         {3'd4, 7'd7}:  ch = 7'h4A;
         {3'd3, 7'd5}:  ch = 7'h4B;
         {3'd4, 7'd4}:  ch = 7'h4C;
         {3'd2, 7'd3}:  ch = 7'h4D;
         {3'd2, 7'd2}:  ch = 7'h4E;
         {3'd3, 7'd7}:  ch = 7'h4F;
         {3'd4, 7'd6}:  ch = 7'h50;
         {3'd4, 7'd13}: ch = 7'h51;
         {3'd3, 7'd2}:  ch = 7'h52;
         {3'd3, 7'd0}:  ch = 7'h53;
         {3'd1, 7'd1}:  ch = 7'h54;
         {3'd3, 7'd1}:  ch = 7'h55;
         {3'd4, 7'd1}:  ch = 7'h56;
         {3'd3, 7'd3}:  ch = 7'h57;
         {3'd4, 7'd9}:  ch = 7'h58;
         {3'd4, 7'd11}: ch = 7'h59;
         {3'd4, 7'd12}: ch = 7'h5A;
         {3'd5, 7'd31}: ch = 7'h30;
         {3'd5, 7'd15}: ch = 7'h31;
         {3'd5, 7'd7}:  ch = 7'h32;
         {3'd5, 7'd3}:  ch = 7'h33;
         {3'd5, 7'd1}:  ch = 7'h34;
         {3'd5, 7'd0}:  ch = 7'h35;
         {3'd5, 7'd16}: ch = 7'h36;
         {3'd5, 7'd24}: ch = 7'h37;
         {3'd5, 7'd28}: ch = 7'h38;
         {3'd5, 7'd30}: ch = 7'h39;
         {3'd6, 7'd21}: ch = 7'h2E;
         {3'd6, 7'd51}: ch = 7'h2C;
         {3'd6, 7'd12}: ch = 7'h3F;
         {3'd5, 7'd17}: ch = 7'h3D;
         {3'd5, 7'd8}:  ch = 7'h26;
         {3'd6, 7'd42}: ch = 7'h3B;
         {3'd5, 7'd22}: ch = 7'h28;
         {3'd6, 7'd45}: ch = 7'h29;
         {3'd6, 7'd56}: ch = 7'h3A;
         {3'd6, 7'd30}: ch = 7'h27;
         {3'd6, 7'd33}: ch = 7'h2D;
         {3'd5, 7'd18}: ch = 7'h2F;
         default:       ch = CHAR_UNKNOWN;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

[rtl/morse_key_stream_decoder.sv]
// ============================================================================
// Morse key stream decoder
// Measures runs of key state, builds Morse letters and sends ASCII characters.
// ============================================================================
// Channel | Direction | tdata              | tlast         | tuser
// req     | in        | [0] key_level      | message_end   | -
// rsp     | out       | [6:0] character    | last_of_item  | -
// csr     | in        | dit_length, 14 bit | -             | -
//
// Each accepted input sample has its zero to four characters ready in the result
// register on the next cycle.
// Each character leaves in its own rsp transfer; the input waits while
// characters of the previous sample are pending, except in the cycle in which
// the last of them is taken.
// Synchronous reset clears all run and letter state and sets dit_length to 960.
// ============================================================================
`default_nettype none

module morse_key_stream_decoder #(
   parameter int unsigned RUN_COUNT_BITS = 16,
   parameter int unsigned MAX_ELEMENTS = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [0] key_level, [7:1] zero
   input  wire logic        req_tlast,    // message_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,    // [6:0] character, [7] zero
   output logic             rsp_tlast,    // last_of_item
   input  wire logic        csr_wr_en,
   input  wire logic [13:0] csr_wr_data
);

   localparam int unsigned CMP_W = (RUN_COUNT_BITS > 16) ? RUN_COUNT_BITS : 16;
   localparam logic [2:0] MAX_CNT = 3'(MAX_ELEMENTS);

   typedef struct packed {
      logic [MAX_ELEMENTS-1:0]      bits;
      logic [2:0]                   cnt;
      logic                         sp;
      logic [1:0]                   n;
      mksd_pkg::char_type [1:0]     ch;
   } letter_type;

   logic [13:0]               dit_ff;
   logic                      active_ff, active_in;
   logic                      level_ff, level_in;
   logic [RUN_COUNT_BITS-1:0] len_ff, len_in;
   logic [MAX_ELEMENTS-1:0]   bits_ff, bits_in;
   logic [2:0]                cnt_ff, cnt_in;
   logic                      sp_ff, sp_in;
   logic [CMP_W-1:0]          two_dit, four_dit;
   logic                      accept;
   logic                      key;
   mksd_pkg::burst_type       burst;

   function automatic letter_type end_letter(letter_type r_i);
      letter_type r;
      mksd_pkg::char_type ch;
      r = r_i;
      if (r.cnt != '0) begin
         if (r.sp) begin
            r.ch[r.n[0]] = mksd_pkg::CHAR_SPACE;
            r.n = r.n + 2'd1;
            r.sp = 1'b0;
         end
         ch = (r.cnt > MAX_CNT) ? mksd_pkg::CHAR_UNKNOWN
                                : mksd_pkg::morse_lookup(r.cnt, 7'(r.bits));
         r.ch[r.n[0]] = ch;
         r.n = r.n + 2'd1;
         r.bits = '0;
         r.cnt = '0;
      end
      return r;
   endfunction

   function automatic letter_type close_run(letter_type r_i, logic lvl,
                                            logic [CMP_W-1:0] len);
      letter_type r;
      r = r_i;
      if (lvl) begin
         if (r.cnt < MAX_CNT) begin
            r.bits = MAX_ELEMENTS'({r.bits, (len >= two_dit)});
         end
         if (r.cnt != 3'd7) begin
            r.cnt = r.cnt + 3'd1;
         end
      end else if (len >= two_dit) begin
         r = end_letter(r);
         if (len >= four_dit) begin
            r.sp = 1'b1;
         end
      end
      return r;
   endfunction

   assign two_dit = CMP_W'({dit_ff, 1'b0});
   assign four_dit = CMP_W'({dit_ff, 2'b00});
   assign key = req_tdata[0];
   assign accept = req_tvalid && req_tready;

   always_comb begin
      letter_type st;
      letter_type a;
      letter_type b;
      logic [1:0] idx;
      st.bits = bits_ff;
      st.cnt = cnt_ff;
      st.sp = sp_ff;
      st.n = '0;
      st.ch = '0;
      a = st;
      active_in = active_ff;
      level_in = level_ff;
      len_in = len_ff;
      if (active_ff && (key != level_ff)) begin
         a = close_run(st, level_ff, CMP_W'(len_ff));
         level_in = key;
         len_in = RUN_COUNT_BITS'(1);
      end else if (active_ff) begin
         if (len_ff != '1) begin
            len_in = len_ff + RUN_COUNT_BITS'(1);
         end
      end else begin
         active_in = 1'b1;
         level_in = key;
         len_in = RUN_COUNT_BITS'(1);
      end
      b = a;
      b.n = '0;
      b.ch = '0;
      if (req_tlast) begin
         b = end_letter(close_run(b, level_in, CMP_W'(len_in)));
         b.sp = 1'b0;
         b.bits = '0;
         b.cnt = '0;
         active_in = 1'b0;
         level_in = 1'b0;
         len_in = '0;
      end
      bits_in = b.bits;
      cnt_in = b.cnt;
      sp_in = b.sp;
      burst.load = accept;
      burst.count = 3'(a.n) + 3'(b.n);
      burst.chars = '0;
      burst.chars[0] = a.ch[0];
      burst.chars[1] = a.ch[1];
      for (int i = 0; i < 2; i++) begin
         idx = a.n + 2'(i);
         if (2'(i) < b.n) begin
            burst.chars[idx] = b.ch[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dit_ff <= 14'd960;
         active_ff <= 1'b0;
         level_ff <= 1'b0;
         len_ff <= '0;
         bits_ff <= '0;
         cnt_ff <= '0;
         sp_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            dit_ff <= csr_wr_data;
         end
         if (accept) begin
            active_ff <= active_in;
            level_ff <= level_in;
            len_ff <= len_in;
            bits_ff <= bits_in;
            cnt_ff <= cnt_in;
            sp_ff <= sp_in;
         end
      end
   end

   mksd_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .burst      (burst),
      .can_load   (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_idle_run_clear: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (len_ff == '0) && !level_ff)
      else $error("Run state is set while no run is open.");

   a_empty_letter: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (bits_ff == '0))
      else $error("Element bits are set in an empty letter.");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> !active_ff && !sp_ff && (cnt_ff == '0))
      else $error("Message end did not clear the decoder state.");

endmodule

`default_nettype wire

[rtl/mksd_rsp_buf.sv]
// ============================================================================
// Morse decoder result buffer
// Holds the characters of one item and sends them one transfer at a time.
// ============================================================================
`default_nettype none

module mksd_rsp_buf (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mksd_pkg::burst_type burst,
   output logic                    can_load,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,   // [6:0] character, [7] zero
   output logic                    rsp_tlast    // last_of_item
);

   logic [mksd_pkg::COUNT_W-1:0] rem_ff, rem_in;
   mksd_pkg::char_type [mksd_pkg::SLOTS-1:0] chars_ff, chars_in;
   logic xfer;

   assign xfer = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (rem_ff != '0);
   assign rsp_tlast = (rem_ff == mksd_pkg::COUNT_W'(1));
   assign rsp_tdata = {1'b0, chars_ff[0]};
   assign can_load = (rem_ff == '0) || (rsp_tlast && rsp_tready);

   always_comb begin
      rem_in = rem_ff;
      chars_in = chars_ff;
      if (burst.load) begin
         rem_in = burst.count;
         chars_in = burst.chars;
      end else if (xfer) begin
         rem_in = rem_ff - mksd_pkg::COUNT_W'(1);
         chars_in = {mksd_pkg::CHAR_SPACE, chars_ff[mksd_pkg::SLOTS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
      chars_ff <= chars_in;
   end

   a_load_room: assert property (@(posedge clock) disable iff (reset)
      burst.load |-> can_load)
      else $error("Result buffer loaded while results were still pending.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= mksd_pkg::COUNT_W'(mksd_pkg::SLOTS))
      else $error("Result buffer count out of range.");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (xfer && !burst.load) |=> rem_ff == $past(rem_ff) - mksd_pkg::COUNT_W'(1))
      else $error("Result buffer did not advance after a transfer.");

endmodule

`default_nettype wire

[tb/sv/tb_morse_key_stream_decoder.sv]
`timescale 1ns / 1ps
// ============================================================================
// Morse key stream decoder testbench
// Streams thresholded key samples into the decoder and predicts the decoded
// characters with a cycle-free model of run measurement, element collection
// and letter lookup. Directed runs cover the register extremes, over-long and
// unknown letters and word gaps; random messages of table letters, noise and
// broken codes follow under several idle and stall patterns.
// ============================================================================
module tb_morse_key_stream_decoder;

   localparam int CLK_HALF = 5;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD = 400;
   localparam int PHASE_SAMPLES = 60;
   localparam int MAX_ELEMS = 6;
   localparam int NUM_CODES = 48;
   localparam logic [15:0] RUN_MAX = 16'hFFFF;

   // Each entry is {element count, code with first element high, character}.
   localparam logic [17:0] MORSE_CODES [NUM_CODES] = '{
      {3'd2, 7'd1, "A"},  {3'd4, 7'd8, "B"},  {3'd4, 7'd10, "C"}, {3'd3, 7'd4, "D"},
      {3'd1, 7'd0, "E"},  {3'd4, 7'd2, "F"},  {3'd3, 7'd6, "G"},  {3'd4, 7'd0, "H"},
      {3'd2, 7'd0, "I"},  {3'd4, 7'd7, "J"},  {3'd3, 7'd5, "K"},  {3'd4, 7'd4, "L"},
      {3'd2, 7'd3, "M"},  {3'd2, 7'd2, "N"},  {3'd3, 7'd7, "O"},  {3'd4, 7'd6, "P"},
      {3'd4, 7'd13, "Q"}, {3'd3, 7'd2, "R"},  {3'd3, 7'd0, "S"},  {3'd1, 7'd1, "T"},
      {3'd3, 7'd1, "U"},  {3'd4, 7'd1, "V"},  {3'd3, 7'd3, "W"},  {3'd4, 7'd9, "X"},
      {3'd4, 7'd11, "Y"}, {3'd4, 7'd12, "Z"},
      {3'd5, 7'd31, "0"}, {3'd5, 7'd15, "1"}, {3'd5, 7'd7, "2"},  {3'd5, 7'd3, "3"},
      {3'd5, 7'd1, "4"},  {3'd5, 7'd0, "5"},  {3'd5, 7'd16, "6"}, {3'd5, 7'd24, "7"},
      {3'd5, 7'd28, "8"}, {3'd5, 7'd30, "9"},
      {3'd6, 7'd21, "."}, {3'd6, 7'd51, ","}, {3'd6, 7'd12, "?"}, {3'd5, 7'd17, "="},
      {3'd5, 7'd8, "&"},  {3'd6, 7'd42, ";"}, {3'd5, 7'd22, "("}, {3'd6, 7'd45, ")"},
      {3'd6, 7'd56, ":"}, {3'd6, 7'd30, 8'h27}, {3'd6, 7'd33, "-"}, {3'd5, 7'd18, "/"}
   };

   typedef struct packed {
      logic               last;
      mksd_pkg::char_type ch;
   } char_result_type;

   class char_scoreboard;
      bit [13:0]       dit;
      bit              in_run;
      bit              level;
      bit [15:0]       run_len;
      bit [5:0]        elem_bits;
      bit [2:0]        elem_cnt;
      bit              gap_pending;
      char_result_type pending_chars[$];
      int              errors;
      int              samples_taken;

      function new();
         dit = 14'd960;
      endfunction

      function int pending();
         return pending_chars.size();
      endfunction

      function void emit_char(mksd_pkg::char_type ch);
         char_result_type r;
         r.last = 1'b0;
         r.ch = ch;
         pending_chars = {pending_chars, r};
      endfunction

      function mksd_pkg::char_type decode_letter();
         if (elem_cnt > MAX_ELEMS) return mksd_pkg::CHAR_UNKNOWN;
         for (int i = 0; i < NUM_CODES; i++) begin
            if (MORSE_CODES[i][17:15] == elem_cnt && MORSE_CODES[i][14:8] == {1'b0, elem_bits})
               return MORSE_CODES[i][6:0];
         end
         return mksd_pkg::CHAR_UNKNOWN;
      endfunction

      function void end_letter();
         if (elem_cnt == 3'd0) return;
         if (gap_pending) begin
            emit_char(mksd_pkg::CHAR_SPACE);
            gap_pending = 1'b0;
         end
         emit_char(decode_letter());
         elem_bits = '0;
         elem_cnt = '0;
      endfunction

      function void close_run();
         int unsigned two_dits;
         int unsigned four_dits;
         two_dits = 2 * dit;
         four_dits = 4 * dit;
         if (level) begin
            if (elem_cnt < MAX_ELEMS) elem_bits = {elem_bits[4:0], run_len >= two_dits};
            if (elem_cnt != 3'd7) elem_cnt++;
         end else if (run_len >= two_dits) begin
            end_letter();
            if (run_len >= four_dits) gap_pending = 1'b1;
         end
      endfunction

      function void note_sample(bit key, bit msg_end);
         int n_before;
         n_before = pending_chars.size();
         samples_taken++;
         if (in_run && key != level) begin
            close_run();
            level = key;
            run_len = 16'd1;
         end else if (in_run) begin
            if (run_len != RUN_MAX) run_len++;
         end else begin
            in_run = 1'b1;
            level = key;
            run_len = 16'd1;
         end
         if (msg_end) begin
            close_run();
            end_letter();
            gap_pending = 1'b0;
            in_run = 1'b0;
            level = 1'b0;
            run_len = '0;
            elem_bits = '0;
            elem_cnt = '0;
         end
         if (pending_chars.size() > n_before) begin
            pending_chars[pending_chars.size() - 1].last = 1'b1;
         end
      endfunction

      function void check_char(logic [7:0] data, logic last);
         char_result_type exp_r;
         if (pending_chars.size() == 0) begin
            $error("unexpected character: actual %h last %b", data[6:0], last);
            errors++;
            return;
         end
         exp_r = pending_chars.pop_front();
         if (data[6:0] !== exp_r.ch) begin
            $error("character: expected %h, actual %h", exp_r.ch, data[6:0]);
            errors++;
         end
         if (last !== exp_r.last) begin
            $error("last_of_item: expected %b, actual %b", exp_r.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [0] key_level, [7:1] zero
   logic        req_tlast = 1'b0;  // message_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [6:0] character, [7] zero
   logic        rsp_tlast;         // last_of_item
   logic        csr_wr_en = 1'b0;
   logic [13:0] csr_wr_data = '0;

   char_scoreboard board;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;

   morse_key_stream_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #CLK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("morse_key_stream_decoder regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_char(rsp_tdata, rsp_tlast);
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_sample(input bit key, input bit msg_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, key};
      req_tlast <= msg_end;
      do @(posedge clock); while (!req_tready);
      board.note_sample(key, msg_end);
   endtask

   task automatic send_run(input bit key, input int count, input bit msg_end);
      for (int i = 0; i < count; i++) send_sample(key, msg_end && i == count - 1);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_dit(input logic [13:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.dit = value;
   endtask

   task automatic send_letter(input bit [7:0] bits, input int count, input int dit,
                              input bit close_msg);
      int len;
      for (int e = 0; e < count; e++) begin
         if (e > 0) send_run(1'b0, $urandom_range(2 * dit - 1, 1), 1'b0);
         if (bits[count - 1 - e]) len = $urandom_range(4 * dit, 2 * dit);
         else len = $urandom_range(2 * dit - 1, dit);
         send_run(1'b1, len, close_msg && e == count - 1);
      end
   endtask

   task automatic send_message(input int dit);
      int       letters;
      int       idx;
      int       count;
      int       gap;
      bit [7:0] bits;
      bit       end_on_mark;
      letters = $urandom_range(4, 1);
      end_on_mark = $urandom_range(1);
      if ($urandom_range(3) == 0) send_run(1'b0, $urandom_range(6 * dit, 1), 1'b0);
      for (int l = 0; l < letters; l++) begin
         if (l > 0) begin
            if ($urandom_range(3) == 0) gap = $urandom_range(6 * dit, 4 * dit);
            else gap = $urandom_range(4 * dit - 1, 2 * dit);
            send_run(1'b0, gap, 1'b0);
         end
         if ($urandom_range(4) == 0) begin
            count = $urandom_range(8, 1);
            bits = $urandom_range(255);
         end else begin
            idx = $urandom_range(NUM_CODES - 1);
            count = MORSE_CODES[idx][17:15];
            bits = {1'b0, MORSE_CODES[idx][14:8]};
         end
         send_letter(bits, count, dit, end_on_mark && l == letters - 1);
      end
      if (!end_on_mark) send_run(1'b0, $urandom_range(6 * dit, 1), 1'b1);
   endtask

   task automatic send_noise();
      int count;
      count = $urandom_range(20, 1);
      for (int i = 0; i < count; i++) send_sample($urandom_range(1), i == count - 1);
   endtask

   initial begin
      int idle_pct [4];
      int stall_pct [4];
      int phase_dit;
      int start_items;
      idle_pct = '{0, 77, 0, 13};
      stall_pct = '{0, 0, 77, 13};
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset dit length: a lone mark closed by message end is a dot.
      send_sample(1'b1, 1'b1);
      send_run(1'b0, 3, 1'b1);

      write_dit(14'd1);
      // Leading word gap, then a sample that releases four characters.
      send_run(1'b0, 4, 1'b0);
      send_run(1'b1, 1, 1'b0);
      send_run(1'b0, 4, 1'b0);
      send_sample(1'b1, 1'b1);
      // Eight dots overflow the element count.
      for (int i = 0; i < 8; i++) begin
         send_run(1'b1, 1, i == 7);
         if (i < 7) send_run(1'b0, 1, 1'b0);
      end
      // Unknown four-element code.
      send_run(1'b1, 1, 1'b0);
      send_run(1'b0, 1, 1'b0);
      send_run(1'b1, 1, 1'b0);
      send_run(1'b0, 1, 1'b0);
      send_run(1'b1, 2, 1'b0);
      send_run(1'b0, 1, 1'b0);
      send_run(1'b1, 2, 1'b1);
      // Trailing word gap is dropped at message end.
      send_run(1'b1, 1, 1'b0);
      send_run(1'b0, 5, 1'b1);

      write_dit(14'd0);
      send_run(1'b1, 1, 1'b0);
      send_run(1'b0, 1, 1'b0);
      send_sample(1'b1, 1'b1);

      // Longest dit length: short runs stay dots and never end the letter.
      write_dit(14'd16383);
      send_run(1'b1, 3, 1'b0);
      send_run(1'b0, 2, 1'b0);
      send_sample(1'b1, 1'b1);

      for (int p = 0; p < 4; p++) begin
         phase_dit = $urandom_range(2, 1);
         write_dit(phase_dit[13:0]);
         send_idle_pct = idle_pct[p];
         recv_stall_pct = stall_pct[p];
         if (p == 0) hold_req++;
         start_items = board.samples_taken;
         while (board.samples_taken - start_items < PHASE_SAMPLES) begin
            if ($urandom_range(9) == 0) send_noise();
            else send_message(phase_dit);
            if ($urandom_range(19) == 0) wait_idle();
         end
      end

      wait_idle();
      if (board.errors == 0 && board.pending() == 0) begin
         $display("morse_key_stream_decoder regression: pass");
      end else begin
         $display("morse_key_stream_decoder regression: fail");
      end
      $finish;
   end

endmodule
